/* hw/rtl/block_rms_of_samples_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the block RMS unit
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BLOCK_RMS_OF_SAMPLES_TOP_DEFINES_SVH
`define BLOCK_RMS_OF_SAMPLES_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define BRMS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("brms assertion failed");

// Consequent checked in the cycle after the antecedent
`define BRMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("brms assertion failed");

`endif

/* hw/rtl/brms_pkg.sv */
// ----------------------------------------------------------------------------
// Block RMS package
// Widths, sequencer states and the command/status types of the divide/root core.
// ----------------------------------------------------------------------------
package brms_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int COUNT_BITS  = 8;
    // Sum of up to 2^COUNT_BITS-1 squares
    localparam int SUM_BITS    = 2 * SAMPLE_BITS + COUNT_BITS;
    // Width of the mean (quotient and radicand)
    localparam int RAD_W       = 2 * SAMPLE_BITS;
    // Width of the shared subtractor: division needs COUNT_BITS+1, root SAMPLE_BITS+2
    localparam int SUB_W       = (COUNT_BITS + 1 > SAMPLE_BITS + 2) ?
                                 COUNT_BITS + 1 : SAMPLE_BITS + 2;
    localparam int STEP_W      = $clog2(RAD_W);

    localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(30);

    typedef enum logic [2:0] {
        T_IDLE,
        T_MUL,
        T_ADD,
        T_CALC,
        T_EMIT
    } brms_top_state_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_DIV,
        C_SQRT
    } brms_core_state_t;

    typedef struct packed {
        logic                  start;
        logic [SUM_BITS-1:0]   sum;
        logic [COUNT_BITS-1:0] divisor;
    } brms_cmd_t;

    typedef struct packed {
        logic                   done;
        logic [SAMPLE_BITS-1:0] root;
    } brms_sts_t;

endpackage

/* hw/rtl/brms_core.sv */
// ----------------------------------------------------------------------------
// Block RMS divide and root core
// Restoring division of the square sum by the sample count, then a
// digit-by-digit square root, both on one shared subtractor.
// ----------------------------------------------------------------------------
module brms_core (
    input  logic               clk,
    input  logic               rst_n,
    input  brms_pkg::brms_cmd_t cmd,
    output brms_pkg::brms_sts_t sts
);
    import brms_pkg::*;

    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(RAD_W - 1);
    localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(SAMPLE_BITS - 1);

    brms_core_state_t       state_reg, state_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [SUB_W-1:0]       rem_reg, rem_next;
    logic [RAD_W-1:0]       quo_reg, quo_next;
    logic [COUNT_BITS-1:0]  den_reg, den_next;
    logic [SAMPLE_BITS-1:0] root_reg, root_next;
    logic                   done_reg, done_next;

    logic [SUB_W-1:0]       sub_a;
    logic [SUB_W-1:0]       sub_b;
    logic [SUB_W:0]         sub_diff;
    logic                   sub_borrow;

    // Shared subtractor
    assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_borrow = sub_diff[SUB_W];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (cmd.start)
                    state_next = C_DIV;
            end
            C_DIV:
            begin
                if (step_reg == '0)
                    state_next = C_SQRT;
            end
            C_SQRT:
            begin
                if (step_reg == '0)
                    state_next = C_IDLE;
            end
            default: state_next = C_IDLE;
        endcase
    end

    // Datapath control
    always_comb
    begin
        sub_a     = '0;
        sub_b     = '0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        root_next = root_reg;
        done_next = 1'b0;
        case (state_reg)
            C_IDLE:
            begin
                if (cmd.start)
                begin
                    // Upper sum bits are already below the divisor
                    rem_next  = SUB_W'(cmd.sum[SUM_BITS-1:RAD_W]);
                    quo_next  = cmd.sum[RAD_W-1:0];
                    den_next  = cmd.divisor;
                    root_next = '0;
                    step_next = DIV_LAST;
                end
            end
            C_DIV:
            begin
                // Shift in one dividend bit, keep one quotient bit
                sub_a    = SUB_W'({rem_reg[COUNT_BITS-1:0], quo_reg[RAD_W-1]});
                sub_b    = SUB_W'(den_reg);
                quo_next = {quo_reg[RAD_W-2:0], ~sub_borrow};
                if (sub_borrow)
                    rem_next = SUB_W'(sub_a[COUNT_BITS-1:0]);
                else
                    rem_next = SUB_W'(sub_diff[COUNT_BITS-1:0]);
                if (step_reg == '0)
                begin
                    rem_next  = '0;
                    step_next = SQRT_LAST;
                end
                else
                    step_next = step_reg - 1'b1;
            end
            C_SQRT:
            begin
                // Bring down two radicand bits, try root*4+1
                sub_a     = SUB_W'({rem_reg[SAMPLE_BITS-1:0], quo_reg[RAD_W-1:RAD_W-2]});
                sub_b     = SUB_W'({root_reg, 2'b01});
                quo_next  = {quo_reg[RAD_W-3:0], 2'b00};
                root_next = {root_reg[SAMPLE_BITS-2:0], ~sub_borrow};
                if (sub_borrow)
                    rem_next = sub_a;
                else
                    rem_next = sub_diff[SUB_W-1:0];
                if (step_reg == '0)
                    done_next = 1'b1;
                else
                    step_next = step_reg - 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            step_reg  <= step_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
        root_reg <= root_next;
    end

    assign sts.done = done_reg;
    assign sts.root = root_reg;

endmodule

/* hw/rtl/block_rms_of_samples_top.sv */
// ----------------------------------------------------------------------------
// Block RMS of converter samples, top level
// Accumulates squared samples and emits floor(sqrt(sum / n)) per block.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries one sample word. A word is taken
//   at a clock edge with in_valid high and in_stall low.
//   Output channel out_valid/out_stall carries one rms_value word, held in an
//   output register until the receiver takes it with out_stall low.
//   cfg_write_en/cfg_write_data set the block length (0 acts as 1); write it
//   only while the block is idle.
//   Sequencing: a sample that does not close a block occupies the unit while
//   it is accepted, squared and accumulated. The closing sample also runs the
//   shared subtractor for 2*SAMPLE_BITS division steps and SAMPLE_BITS root
//   steps before out_valid rises, and the input is ready again in the same
//   cycle.
//   If the previous result is still stalled when a new one is done, the unit
//   holds it and keeps in_stall high until the output register is free.
//   Reset clears the sum, the sample count, the output valid and sets the
//   block length to 30.
// ----------------------------------------------------------------------------
module block_rms_of_samples_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [brms_pkg::SAMPLE_BITS-1:0]     sample,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [brms_pkg::SAMPLE_BITS-1:0]     rms_value,
    input  logic                                 cfg_write_en,
    input  logic [brms_pkg::COUNT_BITS-1:0]      cfg_write_data
);
    import brms_pkg::*;

    brms_top_state_t        state_reg, state_next;
    logic [COUNT_BITS-1:0]  cfg_reg;
    logic [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [COUNT_BITS-1:0]  seen_reg, seen_next;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [RAD_W-1:0]       sq_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] out_reg;

    logic [COUNT_BITS-1:0]  target;
    logic [COUNT_BITS-1:0]  seen_inc;
    logic [SUM_BITS-1:0]    sum_add;
    logic                   close_block;
    logic                   slot_free;
    logic                   load_out;
    brms_cmd_t              cmd;
    brms_sts_t              sts;

    brms_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts)
    );

    // Block bookkeeping
    assign target      = (cfg_reg == '0) ? COUNT_BITS'(1) : cfg_reg;
    assign seen_inc    = seen_reg + 1'b1;
    assign sum_add     = sum_reg + SUM_BITS'(sq_reg);
    assign close_block = (seen_inc >= target);
    assign slot_free   = !out_valid_reg || !out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (in_valid)
                    state_next = T_MUL;
            end
            T_MUL:  state_next = T_ADD;
            T_ADD:  state_next = close_block ? T_CALC : T_IDLE;
            T_CALC:
            begin
                if (sts.done)
                    state_next = T_EMIT;
            end
            T_EMIT:
            begin
                if (slot_free)
                    state_next = T_IDLE;
            end
            default: state_next = T_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        in_stall    = 1'b1;
        cmd.start   = 1'b0;
        cmd.sum     = sum_add;
        cmd.divisor = seen_inc;
        load_out    = 1'b0;
        sum_next    = sum_reg;
        seen_next   = seen_reg;
        case (state_reg)
            T_IDLE: in_stall = 1'b0;
            T_ADD:
            begin
                cmd.start = close_block;
                if (close_block)
                begin
                    sum_next  = '0;
                    seen_next = '0;
                end
                else
                begin
                    sum_next  = sum_add;
                    seen_next = seen_inc;
                end
            end
            T_EMIT: load_out = slot_free;
            default: in_stall = 1'b1;
        endcase
    end

    // Output register valid: set on load, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            cfg_reg       <= COUNT_RESET;
            sum_reg       <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
                cfg_reg <= cfg_write_data;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == T_IDLE && in_valid)
            sample_reg <= sample;
        if (state_reg == T_MUL)
            sq_reg <= RAD_W'(sample_reg) * RAD_W'(sample_reg);
        if (load_out)
            out_reg <= sts.root;
    end

    assign out_valid = out_valid_reg;
    assign rms_value = out_reg;

endmodule

/* hw/rtl/brms_checker.sv */
// ----------------------------------------------------------------------------
// Block RMS port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`include "block_rms_of_samples_top_defines.svh"

module brms_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [brms_pkg::SAMPLE_BITS-1:0] rms_value
);

    // Hold a stalled result word
    `BRMS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `BRMS_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(rms_value))

    // Busy right after taking a sample word
    `BRMS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    // A new result only comes out of a busy sequence
    `BRMS_ASSERT_NOW(a_result_from_busy, $rose(out_valid), $past(in_stall))

endmodule

bind block_rms_of_samples_top brms_checker u_brms_checker (.*);
